/* src/btgr_pkg.sv */
// Shared types, codes and constants of the bitmap text glyph renderer.
package btgr_pkg;

    // Widest font store address over the supported store depths.
    localparam int FONT_AW_MAX = 19;

    // Input operation codes.
    localparam logic [2:0] FUNC_TEXT       = 3'd0;
    localparam logic [2:0] FUNC_LOAD16     = 3'd1;
    localparam logic [2:0] FUNC_LOAD12     = 3'd2;
    localparam logic [2:0] FUNC_LOAD_GLYPH = 3'd3;
    localparam logic [2:0] FUNC_LOAD_CODE  = 3'd4;

    // Configuration register indexes.
    localparam logic REG_FONT_SELECT = 1'b0;
    localparam logic REG_ASCII_COUNT = 1'b1;

    // Character code constants.
    localparam logic [7:0] ASCII_FIRST  = 8'h20;
    localparam logic [7:0] LEAD_MIN     = 8'h80;
    localparam logic [7:0] HANZI_ORIGIN = 8'hA1;
    localparam logic signed [16:0] HANZI_ROW = 17'sd94;
    localparam logic signed [21:0] HANZI12_BASE = 22'sd2304;

    typedef enum logic [1:0] {
        KIND_H16 = 2'd0,
        KIND_H12 = 2'd1,
        KIND_A16 = 2'd2,
        KIND_A12 = 2'd3
    } glyph_kind_t;

    // One glyph job handed from the front end to the row generator.
    typedef struct packed {
        glyph_kind_t            kind;
        logic [FONT_AW_MAX-1:0] base;
        logic [7:0]             x;
        logic [7:0]             y;
        logic                   inv;
    } glyph_cmd_t;

    // Font store write request from the front end.
    typedef struct packed {
        logic        we16;
        logic        we12;
        logic        weg;
        logic [17:0] addr;
        logic [7:0]  data;
    } load_req_t;

    // One output word: a glyph row span.
    typedef struct packed {
        logic [7:0]  pix_x;
        logic [7:0]  pix_y;
        logic [4:0]  span_len;
        logic [15:0] pixels;
        logic        last;
    } span_t;

    // Pixel width of a glyph kind.
    function automatic logic [4:0] glyph_width(input glyph_kind_t k);
        logic [4:0] w;
        case (k)
            KIND_H16: w = 5'd16;
            KIND_H12: w = 5'd12;
            KIND_A16: w = 5'd8;
            KIND_A12: w = 5'd6;
            default:  w = 5'd16;
        endcase
        return w;
    endfunction

    // Index of the final row of a glyph kind.
    function automatic logic [3:0] glyph_last_row(input glyph_kind_t k);
        logic [3:0] r;
        case (k)
            KIND_H16, KIND_A16: r = 4'd15;
            default:            r = 4'd11;
        endcase
        return r;
    endfunction

endpackage

/* src/btgr_ram.sv */
// Generic single write port RAM with a registered read port.
module btgr_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 256,
        localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic             clk,
        input  logic             we,
        input  logic [AW-1:0]    waddr,
        input  logic [WIDTH-1:0] wdata,
        input  logic             re,
        input  logic [AW-1:0]    raddr,
        output logic [WIDTH-1:0] rdata
    );

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

/* src/btgr_fifo.sv */
// Two-entry queue used between the front end, the row generator and the output.
module btgr_fifo
    #(
        parameter int WIDTH = 8
    )
    (
        input  logic             clk,
        input  logic             rst_n,
        input  logic             push,
        input  logic [WIDTH-1:0] din,
        output logic             full,
        input  logic             pop,
        output logic [WIDTH-1:0] dout,
        output logic             empty
    );

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

/* src/btgr_front.sv */
// Front end: accepts words, tracks cursor and lead byte, searches the ASCII table, builds jobs.
module btgr_front
    import btgr_pkg::*;
    #(
        parameter int DISPLAY_WIDTH    = 160,
        parameter int DISPLAY_HEIGHT   = 160,
        parameter int FONT_STORE_DEPTH = 262144,
        parameter int ASCII_ENTRIES    = 128
    )
    (
        input  logic       clk,
        input  logic       rst_n,
        input  logic       cfg_wr_en,
        input  logic       cfg_index,
        input  logic [7:0] cfg_data,
        input  logic       push,
        output logic       full,
        input  logic [2:0] func,
        input  logic [17:0] addr,
        input  logic [7:0] data,
        input  logic [7:0] start_x,
        input  logic [7:0] start_y,
        input  logic       first,
        input  logic       invert,
        input  logic       back_idle,
        input  logic       q_full,
        output logic       q_push,
        output glyph_cmd_t q_cmd,
        output load_req_t  ld
    );

    localparam int CAW = (ASCII_ENTRIES > 1) ? $clog2(ASCII_ENTRIES) : 1;
    localparam int JW  = $clog2(ASCII_ENTRIES + 1);
    localparam logic signed [21:0] DEPTH_S = 22'(FONT_STORE_DEPTH);

    typedef enum logic [6:0] {
        F_IDLE = 7'b0000001,
        F_LOAD = 7'b0000010,
        F_SRD  = 7'b0000100,
        F_SCMP = 7'b0001000,
        F_IDX  = 7'b0010000,
        F_BASE = 7'b0100000,
        F_PUSH = 7'b1000000
    } front_state_t;

    front_state_t      state_reg, state_next;
    logic              font_select_reg, font_select_next;
    logic [7:0]        ascii_count_reg, ascii_count_next;
    logic [7:0]        cursor_reg, cursor_next;
    logic [7:0]        line_reg, line_next;
    logic [7:0]        lead_reg, lead_next;
    logic              lead_pend_reg, lead_pend_next;
    logic              inv_reg, inv_next;
    logic [2:0]        func_reg, func_next;
    logic [17:0]       addr_reg, addr_next;
    logic [7:0]        data_reg, data_next;
    glyph_kind_t       kind_reg, kind_next;
    logic [JW-1:0]     j_reg, j_next;
    logic signed [16:0] idx_reg, idx_next;
    logic signed [21:0] vbase_reg, vbase_next;

    logic              accept;
    logic [JW-1:0]     n_eff;
    logic [7:0]        code_q;
    logic              code_we;
    logic signed [8:0] dl, dt;
    logic signed [21:0] vwrap;
    logic [8:0]        adv_sum;
    logic [7:0]        adv;

    // Reduce an 8-bit value modulo m by binary restoring subtraction.
    function automatic logic [7:0] wrap8(input logic [7:0] v, input int m);
        logic [16:0] r;
        r = 17'(v);
        for (int k = 7; k >= 0; k--)
        begin
            if (r >= (17'(m) << k))
            begin
                r = r - (17'(m) << k);
            end
        end
        return r[7:0];
    endfunction

    assign accept = push && (state_reg == F_IDLE);
    assign full   = (state_reg != F_IDLE);
    assign n_eff  = (ascii_count_reg > 8'(ASCII_ENTRIES)) ? JW'(ASCII_ENTRIES)
                                                          : JW'(ascii_count_reg);

    // ASCII code table, written on load and walked by the search.
    assign code_we = accept && (func == FUNC_LOAD_CODE) && (addr < 18'(ASCII_ENTRIES));

    btgr_ram #(.WIDTH(8), .DEPTH(ASCII_ENTRIES)) u_codes (
        .clk   (clk),
        .we    (code_we),
        .waddr (addr[CAW-1:0]),
        .wdata (data),
        .re    (state_reg == F_SRD),
        .raddr (j_reg[CAW-1:0]),
        .rdata (code_q)
    );

    // Zone and position offsets of a double-byte character.
    assign dl = $signed({1'b0, lead_reg}) - $signed({1'b0, HANZI_ORIGIN});
    assign dt = $signed({1'b0, data_reg}) - $signed({1'b0, HANZI_ORIGIN});

    // Bring a glyph base address into the font store range.
    always_comb
    begin
        if (vbase_reg < -DEPTH_S)
        begin
            vwrap = vbase_reg + DEPTH_S + DEPTH_S;
        end
        else if (vbase_reg < 22'sd0)
        begin
            vwrap = vbase_reg + DEPTH_S;
        end
        else if (vbase_reg >= DEPTH_S)
        begin
            vwrap = vbase_reg - DEPTH_S;
        end
        else
        begin
            vwrap = vbase_reg;
        end
    end

    // Cursor advance by the glyph width.
    assign adv_sum = {1'b0, cursor_reg} + 9'(glyph_width(kind_reg));
    assign adv     = (adv_sum >= 9'(DISPLAY_WIDTH)) ? 8'(adv_sum - 9'(DISPLAY_WIDTH))
                                                    : adv_sum[7:0];

    // Job and load outputs.
    assign q_push     = (state_reg == F_PUSH) && !q_full;
    assign q_cmd.kind = kind_reg;
    assign q_cmd.base = vwrap[FONT_AW_MAX-1:0];
    assign q_cmd.x    = cursor_reg;
    assign q_cmd.y    = line_reg;
    assign q_cmd.inv  = inv_reg;
    assign ld.we16 = (state_reg == F_LOAD) && back_idle && (func_reg == FUNC_LOAD16);
    assign ld.we12 = (state_reg == F_LOAD) && back_idle && (func_reg == FUNC_LOAD12);
    assign ld.weg  = (state_reg == F_LOAD) && back_idle && (func_reg == FUNC_LOAD_GLYPH);
    assign ld.addr = addr_reg;
    assign ld.data = data_reg;

    // Next-state logic.
    always_comb
    begin
        state_next       = state_reg;
        font_select_next = font_select_reg;
        ascii_count_next = ascii_count_reg;
        cursor_next      = cursor_reg;
        line_next        = line_reg;
        lead_next        = lead_reg;
        lead_pend_next   = lead_pend_reg;
        inv_next         = inv_reg;
        func_next        = func_reg;
        addr_next        = addr_reg;
        data_next        = data_reg;
        kind_next        = kind_reg;
        j_next           = j_reg;
        idx_next         = idx_reg;
        vbase_next       = vbase_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FONT_SELECT: font_select_next = cfg_data[0];
                REG_ASCII_COUNT: ascii_count_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    func_next = func;
                    addr_next = addr;
                    data_next = data;
                    case (func)
                        FUNC_TEXT:
                        begin
                            if (first)
                            begin
                                cursor_next    = wrap8(start_x, DISPLAY_WIDTH);
                                line_next      = wrap8(start_y, DISPLAY_HEIGHT);
                                inv_next       = invert;
                                lead_pend_next = 1'b0;
                            end
                            if (lead_pend_reg && !first)
                            begin
                                lead_pend_next = 1'b0;
                                kind_next  = font_select_reg ? KIND_H12 : KIND_H16;
                                state_next = F_IDX;
                            end
                            else if (data >= LEAD_MIN)
                            begin
                                lead_next      = data;
                                lead_pend_next = 1'b1;
                            end
                            else if (data < ASCII_FIRST)
                            begin
                                state_next = F_IDLE;
                            end
                            else if (font_select_reg)
                            begin
                                kind_next  = KIND_A12;
                                state_next = F_IDX;
                            end
                            else if (n_eff != '0)
                            begin
                                kind_next  = KIND_A16;
                                j_next     = '0;
                                state_next = F_SRD;
                            end
                        end
                        FUNC_LOAD16, FUNC_LOAD12:
                        begin
                            state_next = F_LOAD;
                        end
                        FUNC_LOAD_GLYPH:
                        begin
                            if (addr < 18'(ASCII_ENTRIES * 16))
                            begin
                                state_next = F_LOAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            F_LOAD:
            begin
                if (back_idle)
                begin
                    state_next = F_IDLE;
                end
            end
            F_SRD:
            begin
                state_next = F_SCMP;
            end
            F_SCMP:
            begin
                if (code_q == data_reg)
                begin
                    vbase_next = 22'(j_reg) <<< 4;
                    state_next = F_PUSH;
                end
                else if (j_reg + JW'(1) == n_eff)
                begin
                    state_next = F_IDLE;
                end
                else
                begin
                    j_next     = j_reg + JW'(1);
                    state_next = F_SRD;
                end
            end
            F_IDX:
            begin
                idx_next   = 17'(dl) * HANZI_ROW + 17'(dt);
                state_next = F_BASE;
            end
            F_BASE:
            begin
                case (kind_reg)
                    KIND_H16: vbase_next = 22'(idx_reg) * 22'sd32;
                    KIND_H12: vbase_next = HANZI12_BASE + 22'(idx_reg) * 22'sd24;
                    KIND_A12: vbase_next = $signed(22'(data_reg - ASCII_FIRST)) * 22'sd24;
                    default:  vbase_next = vbase_reg;
                endcase
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    cursor_next = adv;
                    state_next  = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= F_IDLE;
            font_select_reg <= 1'b1;
            ascii_count_reg <= 8'd0;
            cursor_reg      <= 8'd0;
            line_reg        <= 8'd0;
            lead_reg        <= 8'd0;
            lead_pend_reg   <= 1'b0;
            inv_reg         <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            font_select_reg <= font_select_next;
            ascii_count_reg <= ascii_count_next;
            cursor_reg      <= cursor_next;
            line_reg        <= line_next;
            lead_reg        <= lead_next;
            lead_pend_reg   <= lead_pend_next;
            inv_reg         <= inv_next;
        end
    end

    // Working registers of the current word.
    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        addr_reg  <= addr_next;
        data_reg  <= data_next;
        kind_reg  <= kind_next;
        j_reg     <= j_next;
        idx_reg   <= idx_next;
        vbase_reg <= vbase_next;
    end

endmodule

/* src/btgr_back.sv */
// Row generator: holds the font stores and turns one job into glyph row spans.
module btgr_back
    import btgr_pkg::*;
    #(
        parameter int DISPLAY_HEIGHT   = 160,
        parameter int FONT_STORE_DEPTH = 262144,
        parameter int ASCII_ENTRIES    = 128
    )
    (
        input  logic       clk,
        input  logic       rst_n,
        input  logic       q_empty,
        output logic       q_pop,
        input  glyph_cmd_t q_cmd,
        input  load_req_t  ld,
        output logic       idle,
        input  logic       out_full,
        output logic       out_push,
        output span_t      out_span
    );

    localparam int AW  = $clog2(FONT_STORE_DEPTH);
    localparam int GAW = $clog2(ASCII_ENTRIES * 16);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_HI   = 4'b0010,
        B_LO   = 4'b0100,
        B_OUT  = 4'b1000
    } back_state_t;

    back_state_t state_reg, state_next;
    glyph_cmd_t  cmd_reg, cmd_next;
    logic [3:0]  row_reg, row_next;
    logic [7:0]  y_reg, y_next;
    logic [7:0]  hi_reg, hi_next;

    logic [4:0]  off;
    logic [AW:0] fsum;
    logic [AW-1:0] faddr;
    logic [GAW-1:0] gaddr;
    logic        re16, re12, reg_g;
    logic [7:0]  q16, q12, qg;
    logic [7:0]  lo;
    logic [15:0] bits;
    logic [4:0]  width;
    logic        last_row;
    logic [8:0]  y_inc;

    // Byte address of the current row in a font store.
    assign off   = {row_reg, (state_reg == B_LO)};
    assign fsum  = {1'b0, cmd_reg.base[AW-1:0]} + (AW+1)'(off);
    assign faddr = (fsum >= (AW+1)'(FONT_STORE_DEPTH))
                 ? AW'(fsum - (AW+1)'(FONT_STORE_DEPTH)) : fsum[AW-1:0];
    assign gaddr = cmd_reg.base[GAW-1:0] + GAW'(row_reg);

    assign re16  = ((state_reg == B_HI) || (state_reg == B_LO)) && (cmd_reg.kind == KIND_H16);
    assign re12  = ((state_reg == B_HI) || (state_reg == B_LO))
                && ((cmd_reg.kind == KIND_H12) || (cmd_reg.kind == KIND_A12));
    assign reg_g = (state_reg == B_HI) && (cmd_reg.kind == KIND_A16);

    btgr_ram #(.WIDTH(8), .DEPTH(FONT_STORE_DEPTH)) u_font16 (
        .clk   (clk),
        .we    (ld.we16),
        .waddr (AW'(ld.addr)),
        .wdata (ld.data),
        .re    (re16),
        .raddr (faddr),
        .rdata (q16)
    );

    btgr_ram #(.WIDTH(8), .DEPTH(FONT_STORE_DEPTH)) u_font12 (
        .clk   (clk),
        .we    (ld.we12),
        .waddr (AW'(ld.addr)),
        .wdata (ld.data),
        .re    (re12),
        .raddr (faddr),
        .rdata (q12)
    );

    btgr_ram #(.WIDTH(8), .DEPTH(ASCII_ENTRIES * 16)) u_glyph (
        .clk   (clk),
        .we    (ld.weg),
        .waddr (ld.addr[GAW-1:0]),
        .wdata (ld.data),
        .re    (reg_g),
        .raddr (gaddr),
        .rdata (qg)
    );

    // Row pixels: right byte only for double-byte glyphs, then invert and mask.
    always_comb
    begin
        case (cmd_reg.kind)
            KIND_H16: lo = q16;
            KIND_H12: lo = q12;
            default:  lo = 8'd0;
        endcase
        width = glyph_width(cmd_reg.kind);
        bits  = {hi_reg, lo};
        if (cmd_reg.inv)
        begin
            bits = ~bits;
        end
        bits = bits & (16'hFFFF << (5'd16 - width));
    end

    assign last_row = (row_reg == glyph_last_row(cmd_reg.kind));
    assign y_inc    = {1'b0, y_reg} + 9'd1;

    assign out_span.pix_x    = cmd_reg.x;
    assign out_span.pix_y    = y_reg;
    assign out_span.span_len = width;
    assign out_span.pixels   = bits;
    assign out_span.last     = last_row;

    assign idle     = (state_reg == B_IDLE);
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign out_push = (state_reg == B_OUT) && !out_full;

    // Row sequencer.
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        row_next   = row_reg;
        y_next     = y_reg;
        hi_next    = hi_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    cmd_next   = q_cmd;
                    row_next   = 4'd0;
                    y_next     = q_cmd.y;
                    state_next = B_HI;
                end
            end
            B_HI:
            begin
                state_next = B_LO;
            end
            B_LO:
            begin
                case (cmd_reg.kind)
                    KIND_H16: hi_next = q16;
                    KIND_A16: hi_next = qg;
                    default:  hi_next = q12;
                endcase
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (!out_full)
                begin
                    if (last_row)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + 4'd1;
                        y_next     = (y_inc == 9'(DISPLAY_HEIGHT)) ? 8'd0 : y_inc[7:0];
                        state_next = B_HI;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        row_reg <= row_next;
        y_reg   <= y_next;
        hi_reg  <= hi_next;
    end

endmodule

/* src/bitmap_text_glyph_renderer.sv */
// Top level of the bitmap text glyph renderer.
//
//  Channel   Handshake                 Word
//  input     push / full               func addr data start_x start_y first invert
//  result    pop / empty               pix_x pix_y span_len pixels last
//  config    cfg_wr_en                 cfg_index cfg_data
//
// In the row generator each glyph row passes through the B_HI and B_LO font
// store read states and the B_OUT output state, which waits while the output
// queue is full. An 8x16 ASCII character first walks the code table, with a
// read state and a compare state per entry. Font store loads wait until the
// row generator is idle. Reset clears the cursor, lead byte and queues; the font
// stores are not cleared. Either side may stall without losing words.
module bitmap_text_glyph_renderer
    import btgr_pkg::*;
    #(
        parameter int DISPLAY_WIDTH    = 160,
        parameter int DISPLAY_HEIGHT   = 160,
        parameter int FONT_STORE_DEPTH = 262144,
        parameter int ASCII_ENTRIES    = 128
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        cfg_wr_en,
        input  logic        cfg_index,
        input  logic [7:0]  cfg_data,
        input  logic        push,
        output logic        full,
        input  logic [2:0]  func,
        input  logic [17:0] addr,
        input  logic [7:0]  data,
        input  logic [7:0]  start_x,
        input  logic [7:0]  start_y,
        input  logic        first,
        input  logic        invert,
        input  logic        pop,
        output logic        empty,
        output logic [7:0]  pix_x,
        output logic [7:0]  pix_y,
        output logic [4:0]  span_len,
        output logic [15:0] pixels,
        output logic        last
    );

    logic       cmd_push, cmd_full, cmd_pop, cmd_empty;
    glyph_cmd_t cmd_in, cmd_out;
    load_req_t  ld;
    logic       back_idle;
    logic       out_push, out_full;
    span_t      span_in, span_out;

    btgr_front #(
        .DISPLAY_WIDTH    (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT   (DISPLAY_HEIGHT),
        .FONT_STORE_DEPTH (FONT_STORE_DEPTH),
        .ASCII_ENTRIES    (ASCII_ENTRIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .func      (func),
        .addr      (addr),
        .data      (data),
        .start_x   (start_x),
        .start_y   (start_y),
        .first     (first),
        .invert    (invert),
        .back_idle (back_idle && cmd_empty),
        .q_full    (cmd_full),
        .q_push    (cmd_push),
        .q_cmd     (cmd_in),
        .ld        (ld)
    );

    // Job queue between the front end and the row generator.
    btgr_fifo #(.WIDTH($bits(glyph_cmd_t))) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_out),
        .empty (cmd_empty)
    );

    btgr_back #(
        .DISPLAY_HEIGHT   (DISPLAY_HEIGHT),
        .FONT_STORE_DEPTH (FONT_STORE_DEPTH),
        .ASCII_ENTRIES    (ASCII_ENTRIES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (cmd_empty),
        .q_pop    (cmd_pop),
        .q_cmd    (cmd_out),
        .ld       (ld),
        .idle     (back_idle),
        .out_full (out_full),
        .out_push (out_push),
        .out_span (span_in)
    );

    // Output queue decouples the row generator from the consumer.
    btgr_fifo #(.WIDTH($bits(span_t))) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (span_in),
        .full  (out_full),
        .pop   (pop),
        .dout  (span_out),
        .empty (empty)
    );

    assign pix_x    = span_out.pix_x;
    assign pix_y    = span_out.pix_y;
    assign span_len = span_out.span_len;
    assign pixels   = span_out.pixels;
    assign last     = span_out.last;

endmodule
